// ----- src/rtpb_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpb_pkg
// Shared types and constants of the ribbon trail point buffer.
// ----------------------------------------------------------------------------
package rtpb_pkg;

  localparam int unsigned POINT_CAPACITY_DEF = 32;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned AGE_W     = 32;
  localparam int unsigned MIN_DIST_W = 31;
  localparam int unsigned MAX_PTS_W = 6;
  localparam int unsigned LIFE_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = '0;
  localparam logic [MAX_PTS_W-1:0]  MAX_PTS_RST  = 6'd32;
  localparam logic [LIFE_W-1:0]     MAX_LIFE_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DISTANCE = 2'd0,
    CFG_MAX_POINTS   = 2'd1,
    CFG_MAX_LIFETIME = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [AGE_W-1:0]          tick_time;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic [AGE_W-1:0]          start_age;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [AGE_W-1:0]          end_age;
    logic                      last_segment;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [AGE_W-1:0]          age;
  } point_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_LOAD   = 3'd1,
    CELL_SHIFT  = 3'd2,
    CELL_AGE    = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    point_t           load_pt;
    logic [AGE_W-1:0] dt;
  } cell_ctl_t;

endpackage

// ----- src/rtpb_stream_if.sv -----
// ----------------------------------------------------------------------------
// rtpb_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface rtpb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ribbon_trail_point_buffer.sv -----
// ----------------------------------------------------------------------------
// ribbon_trail_point_buffer
// Trail point history with distance gating, aging, expiry and segment output.
// ----------------------------------------------------------------------------
// The block takes one tick (position and frame time) per transaction and then
// emits one segment per adjacent pair of stored points, oldest first, the last
// one flagged. Points live in a row of cells that shift toward the head when a
// point is dropped and rotate once around the occupied range to emit segments.
// A tick runs through the distance test on the shared multiplier (skipped when
// the store is empty), the append, the drop of the oldest point at the limit,
// aging, the expiry scan that shifts out each expired point, the emission of
// each segment (held while the output is not ready) and the step that closes
// the rotation; the block then accepts the next tick. The append is skipped
// for a point that is too close, the drop when the limit is not reached, and
// the segment and rotation steps when fewer than two points remain. A new
// tick is taken once the previous one has rotated back; its last segment may
// still wait in the output register.
module ribbon_trail_point_buffer #(
  parameter int unsigned POINT_CAPACITY = rtpb_pkg::POINT_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  rtpb_stream_if.sink         in_if,
  rtpb_stream_if.source       out_if,
  rtpb_stream_if.sink         cfg_if
);
  import rtpb_pkg::*;

  localparam int unsigned CNT_W = $clog2(POINT_CAPACITY + 1);
  localparam int unsigned LIM_W = (CNT_W > MAX_PTS_W) ? CNT_W : MAX_PTS_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DIST    = 8'b0000_0010,
    S_APPEND  = 8'b0000_0100,
    S_DROP    = 8'b0000_1000,
    S_AGE     = 8'b0001_0000,
    S_EXPIRE  = 8'b0010_0000,
    S_EMIT    = 8'b0100_0000,
    S_RESTORE = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        seg_r, seg_nxt;
  logic [MIN_DIST_W-1:0]   min_dist_r;
  logic [MAX_PTS_W-1:0]    max_pts_r;
  logic [LIFE_W-1:0]       max_life_r;
  in_item_t                in_r;
  logic signed [COORD_W-1:0] last_x_r, last_y_r, last_z_r;
  logic                    out_valid_r;
  out_item_t               out_data_r, out_data_nxt;
  logic                    out_load;
  logic                    in_acc;
  logic                    dist_done, dist_far;
  logic [LIM_W-1:0]        limit;
  logic                    last_seg;
  cell_ctl_t               cell_ctl;
  point_t                  cell_q [POINT_CAPACITY];

  assign in_acc = in_if.valid && in_if.ready;

  // Configuration registers.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
      max_pts_r  <= MAX_PTS_RST;
      max_life_r <= MAX_LIFE_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.reg_index)
        CFG_MIN_DISTANCE: min_dist_r <= cfg_if.data.wdata[MIN_DIST_W-1:0];
        CFG_MAX_POINTS:   max_pts_r  <= cfg_if.data.wdata[MAX_PTS_W-1:0];
        CFG_MAX_LIFETIME: max_life_r <= cfg_if.data.wdata[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  rtpb_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && (count_r != '0)),
    .cur_x    (in_if.data.pos_x),
    .cur_y    (in_if.data.pos_y),
    .cur_z    (in_if.data.pos_z),
    .last_x   (last_x_r),
    .last_y   (last_y_r),
    .last_z   (last_z_r),
    .min_dist (min_dist_r),
    .done     (dist_done),
    .far      (dist_far)
  );

  assign limit = (LIM_W'(max_pts_r) < LIM_W'(POINT_CAPACITY)) ?
                 LIM_W'(max_pts_r) : LIM_W'(POINT_CAPACITY);
  assign last_seg = (seg_r == count_r - CNT_W'(2));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    seg_nxt      = seg_r;
    out_load     = 1'b0;
    cell_ctl.op  = CELL_HOLD;
    cell_ctl.load_pt = '{x: in_r.pos_x, y: in_r.pos_y, z: in_r.pos_z, age: '0};
    cell_ctl.dt  = in_r.tick_time;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (count_r == '0) ? S_APPEND : S_DIST;
      end
      S_DIST: begin
        if (dist_done) state_nxt = dist_far ? S_APPEND : S_AGE;
      end
      S_APPEND: begin
        cell_ctl.op = CELL_LOAD;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = (LIM_W'(count_r) + LIM_W'(1) >= limit) ? S_DROP : S_AGE;
      end
      S_DROP: begin
        cell_ctl.op = CELL_SHIFT;
        count_nxt   = count_r - CNT_W'(1);
        state_nxt   = S_AGE;
      end
      S_AGE: begin
        cell_ctl.op = CELL_AGE;
        state_nxt   = S_EXPIRE;
      end
      S_EXPIRE: begin
        if (count_r != '0 && cell_q[0].age >= max_life_r) begin
          cell_ctl.op = CELL_SHIFT;
          count_nxt   = count_r - CNT_W'(1);
        end else if (count_r >= CNT_W'(2)) begin
          seg_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load    = 1'b1;
          cell_ctl.op = CELL_ROTATE;
          seg_nxt     = seg_r + CNT_W'(1);
          if (last_seg) state_nxt = S_RESTORE;
        end
      end
      S_RESTORE: begin
        // One more step brings the oldest point back to the head.
        cell_ctl.op = CELL_ROTATE;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      seg_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      seg_r   <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_r <= in_if.data;
    if (state_r == S_APPEND) begin
      last_x_r <= in_r.pos_x;
      last_y_r <= in_r.pos_y;
      last_z_r <= in_r.pos_z;
    end
  end

  // Point cells; the head feeds every cell for the ring closure.
  for (genvar i = 0; i < POINT_CAPACITY; i++) begin : g_cell
    point_t right;
    if (i == POINT_CAPACITY - 1) begin : g_tail
      assign right = cell_q[i];
    end else begin : g_mid
      assign right = cell_q[i+1];
    end
    rtpb_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .cnt   (count_r),
      .right (right),
      .head  (cell_q[0]),
      .q     (cell_q[i])
    );
  end

  // Output register.
  always_comb begin
    out_data_nxt.start_x      = cell_q[0].x;
    out_data_nxt.start_y      = cell_q[0].y;
    out_data_nxt.start_z      = cell_q[0].z;
    out_data_nxt.start_age    = cell_q[0].age;
    out_data_nxt.end_x        = cell_q[1].x;
    out_data_nxt.end_y        = cell_q[1].y;
    out_data_nxt.end_z        = cell_q[1].z;
    out_data_nxt.end_age      = cell_q[1].age;
    out_data_nxt.last_segment = last_seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // Between ticks the store never holds a full row.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> count_r < CNT_W'(POINT_CAPACITY))
    else $error("point count reached capacity between ticks");

  a_emit_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> count_r >= CNT_W'(2))
    else $error("segment emission with fewer than two points");

  a_dist_owner: assert property (@(posedge clk) disable iff (!rst_n)
    dist_done |-> state_r == S_DIST)
    else $error("distance result outside the distance wait");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_load |-> seg_r <= count_r - CNT_W'(2))
    else $error("segment index ran past the stored points");

endmodule

// ----- src/rtpb_cell.sv -----
// ----------------------------------------------------------------------------
// rtpb_cell
// One stored trail point; loads, ages, shifts or rotates with its neighbors.
// ----------------------------------------------------------------------------
module rtpb_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 6
) (
  input  logic               clk,
  input  rtpb_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   cnt,
  input  rtpb_pkg::point_t   right,
  input  rtpb_pkg::point_t   head,
  output rtpb_pkg::point_t   q
);
  import rtpb_pkg::*;

  point_t           pt_r;
  point_t           pt_nxt;
  logic [AGE_W:0]   age_sum;

  assign age_sum = {1'b0, pt_r.age} + {1'b0, ctl.dt};

  always_comb begin
    pt_nxt = pt_r;
    unique case (ctl.op)
      CELL_HOLD: pt_nxt = pt_r;
      CELL_LOAD: begin
        if (cnt == CNT_W'(INDEX)) pt_nxt = ctl.load_pt;
      end
      CELL_SHIFT: pt_nxt = right;
      CELL_AGE: begin
        // Ages saturate instead of wrapping.
        pt_nxt.age = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
      end
      CELL_ROTATE: begin
        // The tail of the occupied range takes the head, closing the ring.
        pt_nxt = (cnt == CNT_W'(INDEX + 1)) ? head : right;
      end
      default: pt_nxt = pt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign q = pt_r;

endmodule

// ----- src/rtpb_dist.sv -----
// ----------------------------------------------------------------------------
// rtpb_dist
// Exact squared-distance test over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module rtpb_dist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [rtpb_pkg::COORD_W-1:0]   cur_x,
  input  logic signed [rtpb_pkg::COORD_W-1:0]   cur_y,
  input  logic signed [rtpb_pkg::COORD_W-1:0]   cur_z,
  input  logic signed [rtpb_pkg::COORD_W-1:0]   last_x,
  input  logic signed [rtpb_pkg::COORD_W-1:0]   last_y,
  input  logic signed [rtpb_pkg::COORD_W-1:0]   last_z,
  input  logic [rtpb_pkg::MIN_DIST_W-1:0]       min_dist,
  output logic                                  done,
  output logic                                  far
);
  import rtpb_pkg::*;

  localparam logic [2:0] STEP_LIM = 3'd0;
  localparam logic [2:0] STEP_DX  = 3'd1;
  localparam logic [2:0] STEP_DY  = 3'd2;
  localparam logic [2:0] STEP_DZ  = 3'd3;
  localparam logic [2:0] STEP_SUM = 3'd4;
  localparam logic [2:0] STEP_CMP = 3'd5;

  logic                busy_r;
  logic [2:0]          step_r;
  logic [COORD_W-1:0]  dx_r, dy_r, dz_r;
  logic [COORD_W-1:0]  mul_op;
  logic [63:0]         prod_r;
  logic [61:0]         lim_r;
  logic [65:0]         acc_r;

  function automatic logic [COORD_W-1:0] abs_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
  endfunction

  always_comb begin
    case (step_r)
      STEP_LIM: mul_op = {1'b0, min_dist};
      STEP_DX:  mul_op = dx_r;
      STEP_DY:  mul_op = dy_r;
      STEP_DZ:  mul_op = dz_r;
      default:  mul_op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_LIM;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_LIM;
    end else if (busy_r) begin
      if (step_r == STEP_CMP) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  // Product of one step is accumulated in the step after it.
  always_ff @(posedge clk) begin
    if (start) begin
      dx_r  <= abs_diff(cur_x, last_x);
      dy_r  <= abs_diff(cur_y, last_y);
      dz_r  <= abs_diff(cur_z, last_z);
      acc_r <= '0;
    end else if (busy_r) begin
      prod_r <= {32'b0, mul_op} * {32'b0, mul_op};
      if (step_r == STEP_DX) lim_r <= prod_r[61:0];
      if (step_r == STEP_DY || step_r == STEP_DZ || step_r == STEP_SUM) begin
        acc_r <= acc_r + 66'(prod_r);
      end
    end
  end

  assign done = busy_r && (step_r == STEP_CMP);
  assign far  = acc_r >= 66'(lim_r);

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the ribbon trail point buffer. Ticks go in on a valid/ready
// channel while a scoreboard keeps its own trail of points, works out the
// segments each tick must produce and checks every segment that comes out.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpb_pkg::*;

  localparam int unsigned CAPACITY        = POINT_CAPACITY_DEF;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned TICKS_PER_PHASE = 50;

  class trail_scoreboard;
    logic [MIN_DIST_W-1:0] min_dist;
    logic [MAX_PTS_W-1:0]  max_pts;
    logic [LIFE_W-1:0]     max_life;
    point_t                trail[$];
    out_item_t             pending[$];
    int unsigned           fail_count;

    function new();
      min_dist   = MIN_DIST_RST;
      max_pts    = MAX_PTS_RST;
      max_life   = MAX_LIFE_RST;
      fail_count = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MIN_DISTANCE: min_dist = value[MIN_DIST_W-1:0];
        CFG_MAX_POINTS:   max_pts  = value[MAX_PTS_W-1:0];
        CFG_MAX_LIFETIME: max_life = value[LIFE_W-1:0];
        default: ;
      endcase
    endfunction

    static function logic [63:0] span(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [32:0] d;
      logic [32:0]        m;
      d = $signed({a[31], a}) - $signed({b[31], b});
      m = d[32] ? -d : d;
      return {31'b0, m};
    endfunction

    function void note_tick(in_item_t t);
      int unsigned lim;
      logic [63:0] sq_x, sq_y, sq_z, md;
      logic [64:0] acc;
      logic [32:0] aged;
      point_t      last;
      point_t      fresh;
      out_item_t   seg;
      bit          take;
      lim  = (max_pts < CAPACITY) ? max_pts : CAPACITY;
      take = 1'b1;
      if (trail.size() != 0) begin
        last = trail[$];
        sq_x = span(t.pos_x, last.x);
        sq_y = span(t.pos_y, last.y);
        sq_z = span(t.pos_z, last.z);
        sq_x = sq_x * sq_x;
        sq_y = sq_y * sq_y;
        sq_z = sq_z * sq_z;
        md   = 64'(min_dist);
        // A squared distance that does not fit in 64 bits always counts as far.
        acc  = {1'b0, sq_x} + {1'b0, sq_y};
        if (!acc[64]) begin
          acc  = {1'b0, acc[63:0]} + {1'b0, sq_z};
          take = acc[64] || (acc[63:0] >= md * md);
        end
      end
      if (take) begin
        fresh = '{x: t.pos_x, y: t.pos_y, z: t.pos_z, age: '0};
        trail = {trail, fresh};
        if (trail.size() >= lim) trail.delete(0);
      end
      foreach (trail[i]) begin
        aged = {1'b0, trail[i].age} + {1'b0, t.tick_time};
        trail[i].age = aged[32] ? '1 : aged[31:0];
      end
      while (trail.size() > 0 && trail[0].age >= max_life) trail.delete(0);
      for (int i = 0; i + 1 < trail.size(); i++) begin
        seg = '{start_x: trail[i].x, start_y: trail[i].y,
                start_z: trail[i].z, start_age: trail[i].age,
                end_x: trail[i+1].x, end_y: trail[i+1].y,
                end_z: trail[i+1].z, end_age: trail[i+1].age,
                last_segment: (i + 2 == trail.size())};
        pending = {pending, seg};
      end
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 40) $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_segment(out_item_t got);
      out_item_t   want;
      logic [31:0] g[9];
      logic [31:0] w[9];
      string       tag[9];
      if (pending.size() == 0) begin
        report($sformatf("segment with nothing expected: %p", got));
        return;
      end
      want = pending[0];
      pending.delete(0);
      tag = '{"start_x", "start_y", "start_z", "start_age",
              "end_x", "end_y", "end_z", "end_age", "last_segment"};
      g = '{got.start_x, got.start_y, got.start_z, got.start_age,
            got.end_x, got.end_y, got.end_z, got.end_age, 32'(got.last_segment)};
      w = '{want.start_x, want.start_y, want.start_z, want.start_age,
            want.end_x, want.end_y, want.end_z, want.end_age, 32'(want.last_segment)};
      foreach (g[i]) begin
        if (g[i] !== w[i])
          report($sformatf("%s: got %h, expected %h", tag[i], g[i], w[i]));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;

  trail_scoreboard sb = new();

  rtpb_stream_if #(.T(in_item_t))  tick_ch ();
  rtpb_stream_if #(.T(out_item_t)) seg_ch ();
  rtpb_stream_if #(.T(cfg_item_t)) cfg_ch ();

  ribbon_trail_point_buffer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (tick_ch),
    .out_if (seg_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit pause_now();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  function automatic in_item_t mk_tick(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [31:0] dt);
    return '{pos_x: x, pos_y: y, pos_z: z, tick_time: dt};
  endfunction

  // Valid stays high from one transaction to the next unless a gap is taken.
  task automatic send_tick(in_item_t t);
    while (pause_now()) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(t);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: idx, wdata: value};
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, value);
  endtask

  task automatic program_regs(logic [31:0] md, logic [31:0] mp, logic [31:0] life);
    write_reg(CFG_MIN_DISTANCE, md);
    write_reg(CFG_MAX_POINTS, mp);
    write_reg(CFG_MAX_LIFETIME, life);
    cfg_ch.valid <= 1'b0;
  endtask

  // A tick that leaves fewer than two points produces nothing, so the block
  // may still be busy when the queue runs dry; give it time to finish.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    seg_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      seg_ch.ready <= !pause_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && seg_ch.valid && seg_ch.ready) sb.check_segment(seg_ch.data);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((tick_ch.valid && tick_ch.ready) || (seg_ch.valid && seg_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          px, py, pz, off;
    int unsigned step_max, r;
    logic [31:0] md, mp, life, tick_max, dt;
    bit          noisy;
    rst_n         <= 1'b0;
    calm          <= 1'b0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extreme coordinates, a repeated point, a zero tick and a
    // full-range tick that saturates every age and clears the trail.
    send_tick(mk_tick(32'h0, 32'h0, 32'h0, 32'h0));
    send_tick(mk_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1000));
    send_tick(mk_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1000));
    send_tick(mk_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
    send_tick(mk_tick(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'h000F_0000));
    send_tick(mk_tick(32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF));
    settle();

    // Largest spacing and lifetime with a point limit above capacity: opposite
    // corners overflow the squared distance, a one-unit move is rejected and a
    // large tick saturates the ages.
    program_regs(32'h7FFF_FFFF, 32'd63, 32'hFFFF_FFFF);
    send_tick(mk_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
    send_tick(mk_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_tick(mk_tick(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_tick(mk_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_tick(mk_tick(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    settle();

    // Point limits of zero and one keep the trail empty.
    program_regs(32'h0, 32'd0, MAX_LIFE_RST);
    send_tick(mk_tick(32'h10, 32'h20, 32'h30, 32'h100));
    send_tick(mk_tick(32'h40, 32'h50, 32'h60, 32'h100));
    settle();
    program_regs(32'h0, 32'd1, MAX_LIFE_RST);
    send_tick(mk_tick(32'h10, 32'h20, 32'h30, 32'h100));
    send_tick(mk_tick(32'h40, 32'h50, 32'h60, 32'h100));
    settle();

    // Zero lifetime: every point expires in the tick that stores it.
    program_regs(32'h0, 32'd32, 32'h0);
    send_tick(mk_tick(32'h10, 32'h20, 32'h30, 32'h0));
    send_tick(mk_tick(32'h40, 32'h50, 32'h60, 32'h0));
    settle();

    px = 0;
    py = 0;
    pz = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      step_max = (ph == 0) ? 32'h1_0000 : (32'h100 << (8 * $urandom_range(2)));
      noisy    = (ph != 0);
      if (ph == 0) begin
        // Fill the store up to one point below its capacity with long-lived points.
        md   = $urandom_range(0, step_max / 4);
        mp   = 32'd63;
        life = 32'hFFFF_FFFF;
      end else begin
        r = $urandom_range(9);
        if (r < 2) md = 32'h0;
        else if (r < 8) md = $urandom_range(0, 2 * step_max);
        else if (r == 8) md = $urandom & 32'h7FFF_FFFF;
        else md = 32'h7FFF_FFFF;
        r = $urandom_range(9);
        if (ph == 1) mp = $urandom_range(2, 4);
        else if (r == 0) mp = $urandom_range(0, 1);
        else if (r < 3) mp = $urandom_range(33, 63);
        else mp = $urandom_range(2, 32);
        r = $urandom_range(9);
        if (r == 0) life = 32'h0;
        else if (r == 1) life = 32'hFFFF_FFFF;
        else if (r == 2) life = $urandom;
        else life = $urandom_range(1, 16) << 16;
      end
      if (life == 0 || life > 32'h4000_0000) tick_max = 32'h1_0000;
      else tick_max = life / $urandom_range(3, 40);
      calm <= (ph == 3);
      program_regs(md, mp, life);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (noisy && r < 8) begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end else if (r >= 95) begin
          // Stand still: the same point again.
        end else begin
          off = int'($urandom_range(0, 2 * step_max)) - int'(step_max);
          px  = px + off;
          off = int'($urandom_range(0, 2 * step_max)) - int'(step_max);
          py  = py + off;
          off = int'($urandom_range(0, 2 * step_max)) - int'(step_max);
          pz  = pz + off;
        end
        r = $urandom_range(99);
        if (noisy && r < 5) dt = $urandom;
        else if (r < 10) dt = 32'h0;
        else dt = $urandom_range(0, tick_max);
        send_tick(mk_tick(px, py, pz, dt));
      end
      settle();
    end

    if (sb.fail_count == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rtpb_pkg.sv
src/rtpb_stream_if.sv
src/rtpb_cell.sv
src/rtpb_dist.sv
src/ribbon_trail_point_buffer.sv
test/tb_top.sv
